// ===== rtl/kgm_pkg.sv =====
// Shared types and constants of the kernel gas map block.
// Used by kgm_store and by the top level kernel_gas_map_update.
package kgm_pkg;

	// one cell of the map: weight sum (Q16.16) and weighted concentration sum (Q32.16)
	typedef struct packed {
		logic [31:0] ws;
		logic [47:0] cs;
	} kgm_entry_t;

	// action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	// configuration register indexes
	localparam logic [7:0] REG_ORIGIN_X    = 8'd0;
	localparam logic [7:0] REG_ORIGIN_Y    = 8'd1;
	localparam logic [7:0] REG_INV_PITCH_X = 8'd2;
	localparam logic [7:0] REG_INV_PITCH_Y = 8'd3;
	localparam logic [7:0] REG_COEFF_X     = 8'd4;
	localparam logic [7:0] REG_COEFF_Y     = 8'd5;
	localparam logic [7:0] REG_GAIN        = 8'd6;
	localparam logic [7:0] REG_CONF_COEFF  = 8'd7;

	// 1.0 in Q.30
	localparam logic [30:0] ONE30 = 31'h4000_0000;
	// exp(-1) in Q.30 as the truncated 14-term series gives it
	localparam logic [31:0] EXP_M1 = 32'd395007543;
	// exponent (Q.16) from which exp(-e) is taken as zero
	localparam logic [40:0] EXP_LIMIT = 41'd1572864;
	// last series term index
	localparam logic [3:0] SERIES_LAST = 4'd14;

	// floor((2^32-1)/k) for the series divisors
	function automatic logic [31:0] recip_k(input logic [3:0] k);
		logic [31:0] r;
		case (k)
			4'd1: r = 32'd4294967295;
			4'd2: r = 32'd2147483647;
			4'd3: r = 32'd1431655765;
			4'd4: r = 32'd1073741823;
			4'd5: r = 32'd858993459;
			4'd6: r = 32'd715827882;
			4'd7: r = 32'd613566756;
			4'd8: r = 32'd536870911;
			4'd9: r = 32'd477218588;
			4'd10: r = 32'd429496729;
			4'd11: r = 32'd390451572;
			4'd12: r = 32'd357913941;
			4'd13: r = 32'd330382099;
			4'd14: r = 32'd306783378;
			default: r = 32'hFFFF_FFFF;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/kernel_gas_map_update.sv =====
// Kernel gas distribution map: top level, sequencer and configuration registers.
// Depends on kgm_pkg, kgm_mul, kgm_div and kgm_store.
//
// Use: an item is taken when start is high and busy is low. A sample
// (action 0) spreads Gaussian weights over a window of up to
// 2*RANGE_X by 2*RANGE_Y cells around the rounded position and gives no word
// back. A query (action 1) returns one word on average, confidence and
// out_of_map, marked by done for exactly one cycle; the receiver cannot stall.
// Configuration: cfg_valid with cfg_index/cfg_data, cfg_ready is always high;
// write only while busy is low.
// Datapath: all products but the small reciprocal correction go through the one
// registered multiplier, and exp() is a 14-term series followed by one multiply
// by exp(-1) per integer unit of the exponent. A cell whose exponent reaches 24
// skips the series and gets a zero weight; a window wholly off the grid changes
// nothing. An in-map query runs the divider beside the exp sequence; an off-map
// query skips both.
// Reset: the configuration registers take their defaults and the store is swept
// to zero, one cell a cycle over all GRID_X*GRID_Y cells, with busy high meanwhile.
module kernel_gas_map_update #(
	parameter int GRID_X  = 64,
	parameter int GRID_Y  = 64,
	parameter int RANGE_X = 4,
	parameter int RANGE_Y = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [15:0]        concentration,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic [15:0]        average,
	output logic [15:0]        confidence,
	output logic               out_of_map
);

	import kgm_pkg::*;

	localparam int DEPTH = GRID_X * GRID_Y;
	localparam int AW    = $clog2(DEPTH);
	localparam int IXW   = $clog2(GRID_X);
	localparam int IYW   = $clog2(GRID_Y);

	// sequencer codes
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_MX   = 5'd1;
	localparam logic [4:0] ST_MY   = 5'd2;
	localparam logic [4:0] ST_PY   = 5'd3;
	localparam logic [4:0] ST_WIN  = 5'd4;
	localparam logic [4:0] ST_TX1  = 5'd5;
	localparam logic [4:0] ST_TX2  = 5'd6;
	localparam logic [4:0] ST_TX3  = 5'd7;
	localparam logic [4:0] ST_TY1  = 5'd8;
	localparam logic [4:0] ST_TY2  = 5'd9;
	localparam logic [4:0] ST_TY3  = 5'd10;
	localparam logic [4:0] ST_EI   = 5'd11;
	localparam logic [4:0] ST_ET1  = 5'd12;
	localparam logic [4:0] ST_ET2  = 5'd13;
	localparam logic [4:0] ST_ET3  = 5'd14;
	localparam logic [4:0] ST_ECL  = 5'd15;
	localparam logic [4:0] ST_EM1  = 5'd16;
	localparam logic [4:0] ST_EM2  = 5'd17;
	localparam logic [4:0] ST_W1   = 5'd18;
	localparam logic [4:0] ST_W2   = 5'd19;
	localparam logic [4:0] ST_W3   = 5'd20;
	localparam logic [4:0] ST_QRD  = 5'd21;
	localparam logic [4:0] ST_QE   = 5'd22;
	localparam logic [4:0] ST_QC   = 5'd23;

	// rounded magnitude of (c - p) in Q.16; within the window it is at most
	// RANGE+0.5 cells, and 23 bits hold it while that stays below 128 cells
	function automatic logic [22:0] half_mag(input logic [10:0] c,
			input logic signed [57:0] p);
		logic signed [58:0] d;
		logic [58:0]        ad;
		logic [58:0]        r;
		d  = $signed({16'h0, c, 32'h0}) - 59'(p);
		ad = d[58] ? 59'(-d) : 59'(d);
		r  = ad + 59'h8000;
		return r[38:16];
	endfunction

	// configuration registers
	logic signed [31:0] origin_x_q, origin_y_q;
	logic [23:0]        inv_pitch_x_q, inv_pitch_y_q;
	logic [23:0]        coeff_x_q, coeff_y_q;
	logic [15:0]        kernel_gain_q;
	logic [23:0]        conf_coeff_q;

	// item registers
	logic               action_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [15:0]        conc_q;

	logic [4:0]         state_q;
	logic signed [57:0] p_x_q, p_y_q;
	logic signed [25:0] ix_q, iy_q;
	logic [IXW-1:0]     i_q, i_last_q;
	logic [IYW-1:0]     j_q, j_first_q, j_last_q;
	logic [55:0]        tx_q;
	logic [40:0]        e16_q;
	logic [3:0]         k_q;
	logic [4:0]         n_q;
	logic [29:0]        x_q;
	logic [30:0]        term_q, t_q, exp_q;
	logic signed [32:0] sum_q;
	logic [24:0]        w_q;
	logic [31:0]        ws_q;

	logic               done_q, oom_q;
	logic [15:0]        avg_q, conf_q;

	// shared multiplier
	logic [32:0]        mul_a;
	logic [31:0]        mul_b;
	logic [64:0]        prod;

	kgm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// divider for the average
	logic        div_start, div_busy;
	logic [48:0] div_dividend, quot;

	// store
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, cell_addr;
	kgm_entry_t    rd_data, wr_data;
	logic          clr_busy;

	kgm_store #(.DEPTH(DEPTH)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (cell_addr),
		.wr_data  (wr_data),
		.clr_busy (clr_busy)
	);

	kgm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (rd_data.ws),
		.busy     (div_busy),
		.quotient (quot)
	);

	// position offsets from the map origin, as sign and magnitude
	logic signed [32:0] dx_in, dy_in;
	logic [32:0]        mag_x, mag_y;

	assign dx_in = {pos_x_q[31], pos_x_q} - {origin_x_q[31], origin_x_q};
	assign dy_in = {pos_y_q[31], pos_y_q} - {origin_y_q[31], origin_y_q};
	assign mag_x = dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
	assign mag_y = dy_in[32] ? 33'(-dy_in) : 33'(dy_in);

	// cell position (Q.32) and rounded index from the product in flight
	logic [56:0]        idx_sum;
	logic [24:0]        idx_mag;
	logic signed [25:0] idx_pos;
	logic signed [57:0] p_pos;
	logic               neg_now;

	assign neg_now = (state_q == ST_MY) ? dx_in[32] : dy_in[32];
	assign idx_sum = 57'(prod[55:0]) + 57'h8000_0000;
	assign idx_mag = idx_sum[56:32];
	assign idx_pos = neg_now ? -$signed({1'b0, idx_mag}) : $signed({1'b0, idx_mag});
	assign p_pos   = neg_now ? -$signed({2'b0, prod[55:0]}) : $signed({2'b0, prod[55:0]});

	// window bounds, clipped to the grid
	logic signed [26:0] xs, xe, ys, ye, xs_raw, xe_raw, ys_raw, ye_raw, xe_m1, ye_m1;
	logic               win_ok, in_map;

	assign xs_raw = 27'(ix_q) - 27'(RANGE_X);
	assign xe_raw = 27'(ix_q) + 27'(RANGE_X);
	assign ys_raw = 27'(iy_q) - 27'(RANGE_Y);
	assign ye_raw = 27'(iy_q) + 27'(RANGE_Y);
	assign xs     = (xs_raw < 27'sd0) ? 27'sd0 : xs_raw;
	assign xe     = (xe_raw > 27'(GRID_X)) ? 27'(GRID_X) : xe_raw;
	assign ys     = (ys_raw < 27'sd0) ? 27'sd0 : ys_raw;
	assign ye     = (ye_raw > 27'(GRID_Y)) ? 27'(GRID_Y) : ye_raw;
	assign xe_m1  = xe - 27'sd1;
	assign ye_m1  = ye - 27'sd1;
	assign win_ok = (xs < xe) && (ys < ye);
	assign in_map = (ix_q >= 26'sd0) && (ix_q < 26'(GRID_X))
		&& (iy_q >= 26'sd0) && (iy_q < 26'(GRID_Y));

	// per-step arithmetic on the product register
	logic [22:0]  a16_x, a16_y;
	logic [47:0]  sq_sum, w_sum;
	logic [30:0]  sq_now, t_now, em_now;
	logic [24:0]  w_now;
	logic [61:0]  em_sum;
	logic [56:0]  e_sum_s, e_sum_q;
	logic [30:0]  q_est, q_fix;
	logic [34:0]  q_rem;
	logic [32:0]  ws_sum;
	logic [48:0]  cs_sum;

	assign a16_x   = half_mag(11'(i_q), p_x_q);
	assign a16_y   = half_mag(11'(j_q), p_y_q);
	assign sq_sum  = 48'(prod[46:0]) + 48'h8000;
	assign sq_now  = sq_sum[46:16];
	assign t_now   = prod[60:30];
	assign em_sum  = 62'(prod[60:0]) + 62'h2000_0000;
	assign em_now  = em_sum[60:30];
	assign w_sum   = 48'(prod[46:0]) + 48'h20_0000;
	assign w_now   = w_sum[46:22];
	assign e_sum_s = 57'(tx_q) + 57'(prod[55:0]) + 57'h8000;
	assign e_sum_q = 57'(prod[55:0]) + 57'h8000;
	// reciprocal quotient is exact or one short: fix with one compare
	assign q_est   = prod[62:32];
	assign q_rem   = 35'(t_q) - 35'(q_est) * 35'(k_q);
	assign q_fix   = q_est + 31'(q_rem >= 35'(k_q));
	assign ws_sum  = 33'(rd_data.ws) + 33'(w_q);
	assign cs_sum  = 49'(rd_data.cs) + 49'(prod[40:0]);

	// store addressing
	assign cell_addr    = AW'(i_q) * AW'(GRID_Y) + AW'(j_q);
	assign rd_addr      = (state_q == ST_WIN)
		? AW'(ix_q[IXW-1:0]) * AW'(GRID_Y) + AW'(iy_q[IYW-1:0]) : cell_addr;
	assign rd_en        = ((state_q == ST_WIN) && (action_q == ACT_QUERY))
		|| (state_q == ST_W2);
	assign wr_en        = (state_q == ST_W3);
	assign wr_data.ws   = ws_sum[32] ? 32'hFFFF_FFFF : ws_sum[31:0];
	assign wr_data.cs   = cs_sum[48] ? 48'hFFFF_FFFF_FFFF : cs_sum[47:0];
	assign div_start    = (state_q == ST_QRD) && (rd_data.ws != 32'h0);
	assign div_dividend = 49'(rd_data.cs) + 49'(rd_data.ws[31:1]);

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MX: begin
				mul_a = mag_x;
				mul_b = {8'h0, inv_pitch_x_q};
			end
			ST_MY: begin
				mul_a = mag_y;
				mul_b = {8'h0, inv_pitch_y_q};
			end
			ST_TX1: begin
				mul_a = {10'h0, a16_x};
				mul_b = {9'h0, a16_x};
			end
			ST_TX2: begin
				mul_a = {2'b0, sq_now};
				mul_b = {8'h0, coeff_x_q};
			end
			ST_TY1: begin
				mul_a = {10'h0, a16_y};
				mul_b = {9'h0, a16_y};
			end
			ST_TY2: begin
				mul_a = {2'b0, sq_now};
				mul_b = {8'h0, coeff_y_q};
			end
			ST_ET1: begin
				mul_a = {2'b0, term_q};
				mul_b = {2'b0, x_q};
			end
			ST_ET2: begin
				mul_a = {2'b0, t_now};
				mul_b = recip_k(k_q);
			end
			ST_EM1: begin
				mul_a = {2'b0, exp_q};
				mul_b = EXP_M1;
			end
			ST_W1: begin
				mul_a = {17'h0, kernel_gain_q};
				mul_b = {1'b0, exp_q};
			end
			ST_W2: begin
				mul_a = {8'h0, w_now};
				mul_b = {16'h0, conc_q};
			end
			ST_QRD: begin
				mul_a = {1'b0, rd_data.ws};
				mul_b = {8'h0, conf_coeff_q};
			end
			default: begin
			end
		endcase
	end

	// query result arithmetic
	logic [31:0] ex_sum;
	logic [16:0] conf_diff;

	assign ex_sum    = 32'(exp_q) + 32'h2000;
	assign conf_diff = 17'h1_0000 - ex_sum[30:14];

	// configuration writes; indexes past the list drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			inv_pitch_x_q <= 24'd65536;
			inv_pitch_y_q <= 24'd65536;
			coeff_x_q     <= 24'd32768;
			coeff_y_q     <= 24'd32768;
			kernel_gain_q <= 16'd256;
			conf_coeff_q  <= 24'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X:    origin_x_q    <= cfg_data;
				REG_ORIGIN_Y:    origin_y_q    <= cfg_data;
				REG_INV_PITCH_X: inv_pitch_x_q <= cfg_data[23:0];
				REG_INV_PITCH_Y: inv_pitch_y_q <= cfg_data[23:0];
				REG_COEFF_X:     coeff_x_q     <= cfg_data[23:0];
				REG_COEFF_Y:     coeff_y_q     <= cfg_data[23:0];
				REG_GAIN:        kernel_gain_q <= cfg_data[15:0];
				REG_CONF_COEFF:  conf_coeff_q  <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && !busy) begin
						state_q <= ST_MX;
					end
				end
				ST_MX: state_q <= ST_MY;
				ST_MY: state_q <= ST_PY;
				ST_PY: state_q <= ST_WIN;
				ST_WIN: begin
					if (action_q == ACT_QUERY) begin
						if (in_map) begin
							state_q <= ST_QRD;
						end else begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						// a window wholly off the grid changes nothing
						state_q <= win_ok ? ST_TX1 : ST_IDLE;
					end
				end
				ST_TX1: state_q <= ST_TX2;
				ST_TX2: state_q <= ST_TX3;
				ST_TX3: state_q <= ST_TY1;
				ST_TY1: state_q <= ST_TY2;
				ST_TY2: state_q <= ST_TY3;
				ST_TY3: state_q <= ST_EI;
				ST_EI: begin
					if (e16_q >= EXP_LIMIT) begin
						state_q <= (action_q == ACT_QUERY) ? ST_QC : ST_W1;
					end else begin
						state_q <= ST_ET1;
					end
				end
				ST_ET1: state_q <= ST_ET2;
				ST_ET2: state_q <= ST_ET3;
				ST_ET3: state_q <= (k_q == SERIES_LAST) ? ST_ECL : ST_ET1;
				ST_ECL: begin
					if (n_q == 5'd0) begin
						state_q <= (action_q == ACT_QUERY) ? ST_QC : ST_W1;
					end else begin
						state_q <= ST_EM1;
					end
				end
				ST_EM1: state_q <= ST_EM2;
				ST_EM2: begin
					if (n_q == 5'd1) begin
						state_q <= (action_q == ACT_QUERY) ? ST_QC : ST_W1;
					end else begin
						state_q <= ST_EM1;
					end
				end
				ST_W1: state_q <= ST_W2;
				ST_W2: state_q <= ST_W3;
				ST_W3: begin
					// advance over the window, column fastest
					if (j_q != j_last_q) begin
						state_q <= ST_TY1;
					end else if (i_q != i_last_q) begin
						state_q <= ST_TX1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_QRD: state_q <= ST_QE;
				ST_QE:  state_q <= ST_EI;
				ST_QC: begin
					if (!div_busy) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start && !busy) begin
					action_q <= action;
					pos_x_q  <= pos_x;
					pos_y_q  <= pos_y;
					conc_q   <= concentration;
				end
			end
			ST_MY: begin
				p_x_q <= p_pos;
				ix_q  <= idx_pos;
			end
			ST_PY: begin
				p_y_q <= p_pos;
				iy_q  <= idx_pos;
			end
			ST_WIN: begin
				i_q       <= xs[IXW-1:0];
				i_last_q  <= xe_m1[IXW-1:0];
				j_q       <= ys[IYW-1:0];
				j_first_q <= ys[IYW-1:0];
				j_last_q  <= ye_m1[IYW-1:0];
				avg_q     <= '0;
				conf_q    <= '0;
				oom_q     <= !in_map;
			end
			ST_TX3: tx_q <= prod[55:0];
			ST_TY3: e16_q <= e_sum_s[56:16];
			ST_EI: begin
				exp_q  <= '0;
				n_q    <= e16_q[20:16];
				x_q    <= {e16_q[15:0], 14'h0};
				term_q <= ONE30;
				sum_q  <= 33'(ONE30);
				k_q    <= 4'd1;
			end
			ST_ET2: t_q <= t_now;
			ST_ET3: begin
				term_q <= q_fix;
				sum_q  <= k_q[0] ? sum_q - 33'(q_fix) : sum_q + 33'(q_fix);
				k_q    <= k_q + 4'd1;
			end
			ST_ECL: begin
				if (sum_q < 33'sd0) begin
					exp_q <= '0;
				end else if (sum_q > 33'(ONE30)) begin
					exp_q <= ONE30;
				end else begin
					exp_q <= sum_q[30:0];
				end
			end
			ST_EM2: begin
				exp_q <= em_now;
				n_q   <= n_q - 5'd1;
			end
			ST_W2: w_q <= w_now;
			ST_W3: begin
				if (j_q != j_last_q) begin
					j_q <= j_q + 1'b1;
				end else begin
					j_q <= j_first_q;
					i_q <= i_q + 1'b1;
				end
			end
			ST_QRD: ws_q <= rd_data.ws;
			ST_QE:  e16_q <= e_sum_q[56:16];
			ST_QC: begin
				if (ws_q == 32'h0) begin
					avg_q <= '0;
				end else begin
					avg_q <= (|quot[48:16]) ? 16'hFFFF : quot[15:0];
				end
				conf_q <= conf_diff[16] ? 16'hFFFF : conf_diff[15:0];
			end
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != ST_IDLE) || clr_busy;
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign average    = avg_q;
	assign confidence = conf_q;
	assign out_of_map = oom_q;

endmodule

// ===== rtl/kgm_mul.sv =====
// Shared registered multiplier of the kernel gas map block.
// Stand-alone; product appears in the cycle after the operands.
module kgm_mul (
	input  logic        clk,
	input  logic [32:0] a,
	input  logic [31:0] b,
	output logic [64:0] p
);

	always_ff @(posedge clk) begin
		p <= 65'(a) * 65'(b);
	end

endmodule

// ===== rtl/kgm_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, 49 by 32 bits.
// Stand-alone; used for the cell average.
module kgm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [48:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [48:0] quotient
);

	logic [31:0] rem_q;
	logic [48:0] quo_q;
	logic [31:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] sh;
	logic [32:0] diff;
	logic        ge;

	assign sh   = {rem_q, quo_q[48]};
	assign ge   = sh >= {1'b0, div_q};
	assign diff = sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd48;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			// shift in one dividend bit, subtract when it fits
			rem_q <= ge ? diff[31:0] : sh[31:0];
			quo_q <= {quo_q[47:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/kgm_store.sv =====
// Cell store of the kernel gas map: one read and one write port, registered read.
// Depends on kgm_pkg for the entry type; runs a clearing pass after reset.
module kgm_store #(
	parameter  int DEPTH = 4096,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output kgm_pkg::kgm_entry_t rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  kgm_pkg::kgm_entry_t wr_data,
	output logic                clr_busy
);

	import kgm_pkg::*;

	kgm_entry_t    mem [DEPTH];
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clr_busy = clr_q;

endmodule
